// ===== rtl/core/v3n_pkg.sv =====
// Shared constants for the vector normaliser.
`default_nettype none
package v3n_pkg;
  localparam int UNIT_FRAC = 30;
  localparam int OUT_W     = 32;
endpackage
`default_nettype wire

// ===== rtl/core/vector3_normalize.sv =====
// Top level: three-lane vector normaliser with a skid output stage.
//
// Input stream s_axis_*: tdata holds vec_x, vec_y, vec_z (COMPONENT_WIDTH bits each).
// Output stream m_axis_*: tdata holds unit_x, unit_y, unit_z (Q1.30), magnitude
// (Q16.16, low 32 bits); tuser holds zero_vector.
// Three lanes take absolute values and squares, a merge stage sums them, a
// bit-per-stage root pipeline gives the magnitude, and three divider lanes
// form the unit components.
// Throughput: one item per cycle while the skid buffer has room. The
// pipeline is the root pipeline (one stage per magnitude bit) and the
// divider (31 stages), plus squaring, merge and output registers.
// The whole pipeline advances only while its last stage can move on; a
// two-entry skid buffer at the output lets s_axis_tready stay registered.
// When the receiver stalls, items are held in place and none are lost.
// Reset clears the valid flags; data registers are not reset.
`default_nettype none
module vector3_normalize
  import v3n_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // vec_x, vec_y, vec_z from the lowest bit up
  input  wire logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // unit_x, unit_y, unit_z, magnitude from the lowest bit up
  output logic [127:0]                      m_axis_tdata,
  // zero_vector
  output logic                              m_axis_tuser
);
  localparam int CW  = COMPONENT_WIDTH;
  localparam int LAT = 3 + (CW + 1) + (UNIT_FRAC + 1);

  logic en;
  logic [LAT-1:0] vld;
  logic [CW-1:0]  mag [3];
  logic           neg [3];
  logic [2*CW-1:0] sq [3];
  logic [2*CW+1:0] sum;
  logic [3*CW+2:0] pk, pk_q;
  logic [CW-1:0]   root;
  logic [OUT_W-1:0] q [3];
  logic [CW-1:0]   root_d;
  logic [CW-1:0]   root_pipe [UNIT_FRAC+1];

  // pipeline advances unless the spare output entry is full
  logic [128:0] sk0, sk1;
  logic         sk0_v, sk1_v;
  assign en = !sk1_v;
  assign s_axis_tready = en;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    v3n_square #(.CW(CW)) u_sq (
      .clk(clk), .en(en), .comp(s_axis_tdata[k*CW +: CW]),
      .mag(mag[k]), .neg(neg[k]), .sq(sq[k])
    );
  end

  // merge: sum of squares, carry lane data beside it
  logic [2*CW+1:0] sum_r;
  logic [3*CW+2:0] pk_r;
  assign sum = (2*CW+2)'(sq[0]) + (2*CW+2)'(sq[1]) + (2*CW+2)'(sq[2]);
  assign pk  = {neg[2], neg[1], neg[0], mag[2], mag[1], mag[0]};
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum;
      pk_r  <= pk;
    end
  end

  logic [CW:0] root_pipe_in;
  v3n_sqrt #(.RW(CW + 1), .DW(3*CW+3)) u_sqrt (
    .clk(clk), .en(en), .rad(sum_r), .din(pk_r),
    .root(root_pipe_in), .dout(pk_q)
  );
  assign root = CW'(root_pipe_in);

  for (genvar k = 0; k < 3; k++) begin : g_div
    v3n_div #(.MW(CW)) u_div (
      .clk(clk), .en(en), .num(pk_q[k*CW +: CW]), .den(root),
      .neg(pk_q[3*CW + k]), .quot(q[k])
    );
  end

  // magnitude delayed alongside the divider stages
  assign root_pipe[0] = root;
  for (genvar i = 0; i < UNIT_FRAC + 1; i++) begin : g_rd
    if (i < UNIT_FRAC) begin : g_r
      always_ff @(posedge clk) if (en) root_pipe[i+1] <= root_pipe[i];
    end
  end
  always_ff @(posedge clk) if (en) root_d <= root_pipe[UNIT_FRAC];

  // valid flags along the pipeline
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], s_axis_tvalid};
  end

  logic [128:0] res;
  assign res = {root_d == '0, OUT_W'(root_d), q[2], q[1], q[0]};

  // two-entry output queue; enable drops as soon as the second fills
  always_ff @(posedge clk) begin
    if (rst) begin
      sk0_v <= 1'b0;
      sk1_v <= 1'b0;
    end else begin
      logic push, pop;
      push = en && vld[LAT-1];
      pop  = sk0_v && m_axis_tready;
      if (pop) begin
        sk0_v <= sk1_v || push;
        sk1_v <= sk1_v && push;
        sk0   <= sk1_v ? sk1 : res;
        if (sk1_v && push) sk1 <= res;
      end else if (push) begin
        if (!sk0_v) begin
          sk0_v <= 1'b1;
          sk0   <= res;
        end else begin
          sk1_v <= 1'b1;
          sk1   <= res;
        end
      end
    end
  end
  assign m_axis_tvalid = sk0_v;
  assign m_axis_tdata  = sk0[127:0];
  assign m_axis_tuser  = sk0[128];

  // queue never holds a second item without a first
  assert property (@(posedge clk) disable iff (rst) sk1_v |-> sk0_v)
    else $error("skid order broken");
  // input is refused only while the spare entry is full
  assert property (@(posedge clk) disable iff (rst) !s_axis_tready |-> sk1_v)
    else $error("spurious stall");
  // a zero flag comes with a zero magnitude field
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[127:96] == '0))
    else $error("zero flag mismatch");
endmodule
`default_nettype wire

// ===== rtl/core/v3n_square.sv =====
// One component lane: absolute value and square, pipelined over two stages.
`default_nettype none
module v3n_square
  import v3n_pkg::*;
#(
  parameter int CW = 32
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [CW-1:0]   comp,
  output logic [CW-1:0]        mag,
  output logic                 neg,
  output logic [2*CW-1:0]      sq
);
  logic [CW-1:0] mag_r;
  logic          neg_r;
  localparam int HW = (CW + 1) / 2;
  logic [HW-1:0] lo_r, hi_r;
  logic [2*HW-1:0] ll, hh, lh;

  // stage 1: magnitude of the two's complement component
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= comp[CW-1];
      mag_r <= comp[CW-1] ? (~comp + CW'(1)) : comp;
    end
  end
  assign lo_r = HW'(mag_r);
  assign hi_r = HW'(mag_r >> HW);

  // stage 2: square from half-width partial products, each HW bits by HW bits
  always_ff @(posedge clk) begin
    if (en) begin
      ll  <= lo_r * lo_r;
      hh  <= hi_r * hi_r;
      lh  <= lo_r * hi_r;
      mag <= mag_r;
      neg <= neg_r;
    end
  end
  assign sq = (2*CW)'(({{(4*HW){1'b0}}, ll}) + ({{(2*HW){1'b0}}, hh} << (2*HW))
            + ({{(4*HW){1'b0}}, lh} << (HW + 1)));
endmodule
`default_nettype wire

// ===== rtl/core/v3n_sqrt.sv =====
// Pipelined floor square root, one result bit per stage.
`default_nettype none
module v3n_sqrt
  import v3n_pkg::*;
#(
  parameter int RW = 32,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [2*RW-1:0] rad,
  input  wire logic [DW-1:0] din,
  output logic [RW-1:0]      root,
  output logic [DW-1:0]      dout
);
  logic [2*RW-1:0] rad_s [RW+1];
  logic [RW+1:0]   rem_s [RW+1];
  logic [RW-1:0]   root_s[RW+1];
  logic [DW-1:0]   d_s   [RW+1];

  assign rad_s[0]  = rad;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign d_s[0]    = din;

  // each stage brings down one bit pair and tries the next root bit
  for (genvar i = 0; i < RW; i++) begin : g_st
    logic [RW+1:0] r2, tr;
    assign r2 = {rem_s[i][RW-1:0], rad_s[i][2*RW-1 -: 2]};
    assign tr = {root_s[i], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        rad_s[i+1]  <= rad_s[i] << 2;
        d_s[i+1]    <= d_s[i];
        if (r2 >= tr) begin
          rem_s[i+1]  <= r2 - tr;
          root_s[i+1] <= {root_s[i][RW-2:0], 1'b1};
        end else begin
          rem_s[i+1]  <= r2;
          root_s[i+1] <= {root_s[i][RW-2:0], 1'b0};
        end
      end
    end
  end
  assign root = root_s[RW];
  assign dout = d_s[RW];
endmodule
`default_nettype wire

// ===== rtl/core/v3n_div.sv =====
// Pipelined restoring divider for one lane: floor(a * 2^30 / m) with a <= m.
`default_nettype none
module v3n_div
  import v3n_pkg::*;
#(
  parameter int MW = 32
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [MW-1:0] num,
  input  wire logic [MW-1:0] den,
  input  wire logic          neg,
  output logic [OUT_W-1:0]   quot
);
  localparam int NS = UNIT_FRAC + 1;
  logic [MW:0]          r_s  [NS+1];
  logic [MW-1:0]        m_s  [NS+1];
  logic [UNIT_FRAC:0]   q_s  [NS+1];
  logic                 n_s  [NS+1];

  assign r_s[0] = {1'b0, num};
  assign m_s[0] = den;
  assign q_s[0] = '0;
  assign n_s[0] = neg;

  // stage 0 gives the integer bit, the rest one fraction bit each
  for (genvar i = 0; i < NS; i++) begin : g_st
    logic [MW:0] rr;
    assign rr = (i == 0) ? r_s[i] : {r_s[i][MW-1:0], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        m_s[i+1] <= m_s[i];
        n_s[i+1] <= n_s[i];
        if (m_s[i] != '0 && rr >= {1'b0, m_s[i]}) begin
          r_s[i+1] <= rr - {1'b0, m_s[i]};
          q_s[i+1] <= {q_s[i][UNIT_FRAC-1:0], 1'b1};
        end else begin
          r_s[i+1] <= rr;
          q_s[i+1] <= {q_s[i][UNIT_FRAC-1:0], 1'b0};
        end
      end
    end
  end

  // sign restore; a zero divisor leaves zero quotient bits
  always_comb begin
    quot = OUT_W'(q_s[NS]);
    if (n_s[NS]) quot = ~quot + OUT_W'(1);
  end
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the three-component vector normaliser.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import v3n_pkg::*;

  localparam int CW       = 32;
  localparam int IN_W     = ((3*CW+7)/8)*8;
  localparam int LATENCY  = CW + 35;
  localparam int N_RANDOM = 1080;

  typedef struct packed {
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
  } vec_t;

  typedef struct packed {
    logic        zero;
    logic [31:0] mag;
    logic [31:0] uz;
    logic [31:0] uy;
    logic [31:0] ux;
  } norm_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [127:0]     m_axis_tdata;
  logic             m_axis_tuser;

  vec_t  pending_vecs[$];
  norm_t expected_norms[$];
  int    mismatches = 0;
  bit    quiet_phase = 1'b0;
  bit    hold_sender = 1'b0;
  bit    in_taken = 1'b0;
  int    send_gap = 0;
  int    sink_gap = 0;

  vector3_normalize #(.COMPONENT_WIDTH(CW)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floor root of the squared length, then truncated Q1.30 quotients
  function automatic norm_t normalise(vec_t v);
    logic [CW-1:0]  a[3];
    logic           neg[3];
    logic [127:0]   sum;
    logic [127:0]   rem;
    logic [127:0]   trial;
    logic [63:0]    root;
    logic [127:0]   q;
    logic [31:0]    u[3];
    norm_t          r;
    a[0] = v.x; a[1] = v.y; a[2] = v.z;
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      neg[k] = a[k][CW-1];
      if (neg[k]) a[k] = -a[k];
      sum += 128'(a[k]) * 128'(a[k]);
    end
    root = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((sum >> (2*i)) & 128'd3);
      trial = (128'(root) << 2) | 128'd1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (root == 0) begin
        u[k] = '0;
      end else begin
        q = (128'(a[k]) << UNIT_FRAC) / 128'(root);
        u[k] = neg[k] ? -q[31:0] : q[31:0];
      end
    end
    r.ux = u[0]; r.uy = u[1]; r.uz = u[2];
    r.mag = root[31:0];
    r.zero = (root == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic logic [CW-1:0] rand_component();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return {1'b0, {(CW-1){1'b1}}};
      3: return CW'($signed($urandom_range(0, 511)) - 256);
      4: return CW'($urandom_range(0, 1) ? -32'sd65536 : 32'sd65536);
      default: return CW'($urandom);
    endcase
  endfunction

  // Driver: one item per accepted handshake, with random gaps
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || in_taken) begin
        in_taken = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 6);
          s_axis_tvalid <= 1'b0;
        end else if (pending_vecs.size() > 0 && !hold_sender) begin
          s_axis_tdata  <= IN_W'(pending_vecs.pop_front());
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      // receiver stalls
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(0, 6);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: record accepted inputs, compare each result with the oldest expectation
  always @(posedge clk) begin
    norm_t got;
    norm_t want;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_norms.push_back(normalise(vec_t'(s_axis_tdata[3*CW-1:0])));
      in_taken = 1'b1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata};
      if (expected_norms.size() == 0) begin
        $display("unexpected result item at %0t", $realtime);
        mismatches++;
      end else begin
        want = expected_norms.pop_front();
        if (got.ux !== want.ux) report_mismatch("unit_x", got.ux, want.ux);
        if (got.uy !== want.uy) report_mismatch("unit_y", got.uy, want.uy);
        if (got.uz !== want.uz) report_mismatch("unit_z", got.uz, want.uz);
        if (got.mag !== want.mag) report_mismatch("magnitude", got.mag, want.mag);
        if (got.zero !== want.zero)
          report_mismatch("zero_vector", 32'(got.zero), 32'(want.zero));
      end
    end
  end

  function automatic vec_t mk(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
    vec_t v;
    v.x = x; v.y = y; v.z = z;
    return v;
  endfunction

  initial begin
    logic [CW-1:0] mn;
    logic [CW-1:0] mx;
    mn = {1'b1, {(CW-1){1'b0}}};
    mx = {1'b0, {(CW-1){1'b1}}};
    // directed: zero vector, extremes, axis units, tiny values
    pending_vecs.push_back(mk('0, '0, '0));
    pending_vecs.push_back(mk(mn, '0, '0));
    pending_vecs.push_back(mk('0, mn, '0));
    pending_vecs.push_back(mk('0, '0, mn));
    pending_vecs.push_back(mk(mn, mn, mn));
    pending_vecs.push_back(mk(mx, mx, mx));
    pending_vecs.push_back(mk(mx, mn, mx));
    pending_vecs.push_back(mk(32'd1, '0, '0));
    pending_vecs.push_back(mk('0, '0, -32'sd1));
    pending_vecs.push_back(mk(32'd1, 32'd1, 32'd1));
    pending_vecs.push_back(mk(32'h10000, '0, '0));
    pending_vecs.push_back(mk('0, -32'sh10000, '0));
    pending_vecs.push_back(mk(32'h30000, 32'h40000, '0));
    pending_vecs.push_back(mk(-32'sh20000, 32'h20000, -32'sh10000));
    pending_vecs.push_back(mk(mx, '0, 32'd1));
    pending_vecs.push_back(mk(32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // wait until the directed part has fully drained
    wait (pending_vecs.size() == 0);
    hold_sender = 1'b1;
    wait (expected_norms.size() == 0 && !s_axis_tvalid);
    repeat (LATENCY + 5) @(posedge clk);
    wait (expected_norms.size() == 0);
    hold_sender = 1'b0;
    for (int n = 0; n < N_RANDOM; n++)
      pending_vecs.push_back(mk(rand_component(), rand_component(), rand_component()));
    wait (pending_vecs.size() < 150);
    quiet_phase = 1'b1;
    wait (pending_vecs.size() == 0);
    @(posedge clk);
    wait (expected_norms.size() == 0 && !s_axis_tvalid);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_norms.size() == 0) begin
      $display("vector3_normalize regression: pass");
    end else begin
      $display("vector3_normalize regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("vector3_normalize regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
